>>> design/dqpc_pkg.sv
// Shared constants, codes and command types of the dq frame power calculator.
package dqpc_pkg;

  // Default values for the top-level parameters.
  localparam int ANGLE_BITS_DEF      = 16;
  localparam int SAMPLE_BITS_DEF     = 16;
  localparam int SINE_TABLE_BITS_DEF = 10;

  // Fixed field widths at the ports.
  localparam int SAMPLE_W    = 16;
  localparam int STEP_W      = 16;
  localparam int DQ_W        = 18;
  localparam int PWR_W       = 37;
  localparam int ANGLE_OUT_W = 16;

  // Fixed-point constants.
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam int          K_Q15       = 26755;
  localparam int          DQ_MAX      = 131071;
  localparam int          DQ_MIN      = -131072;

  // Which of the three phase angles the datapath works on.
  typedef enum logic [1:0] {
    PH_A = 2'd0,
    PH_B = 2'd1,
    PH_C = 2'd2
  } phase_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_in;
    logic       lookup;
    logic       mac;
    logic       scale;
    logic       rnd;
    logic       load_out;
    phase_sel_e phase;
  } cmd_t;

endpackage

>>> design/dqpc_in_if.sv
// Request channel carrying one set of three-phase voltage and current samples.
interface dqpc_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [dqpc_pkg::SAMPLE_W-1:0]  va;
  logic signed [dqpc_pkg::SAMPLE_W-1:0]  vb;
  logic signed [dqpc_pkg::SAMPLE_W-1:0]  vc;
  logic signed [dqpc_pkg::SAMPLE_W-1:0]  ia;
  logic signed [dqpc_pkg::SAMPLE_W-1:0]  ib;
  logic signed [dqpc_pkg::SAMPLE_W-1:0]  ic;

  modport source (output valid, va, vb, vc, ia, ib, ic, input ready);
  modport sink   (input valid, va, vb, vc, ia, ib, ic, output ready);
endinterface

>>> design/dqpc_out_if.sv
// Result channel carrying d/q values, active and reactive power and the angle.
interface dqpc_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [dqpc_pkg::DQ_W-1:0]        vd;
  logic signed [dqpc_pkg::DQ_W-1:0]        vq;
  logic signed [dqpc_pkg::DQ_W-1:0]        id_out;
  logic signed [dqpc_pkg::DQ_W-1:0]        iq_out;
  logic signed [dqpc_pkg::PWR_W-1:0]       p_active;
  logic signed [dqpc_pkg::PWR_W-1:0]       q_reactive;
  logic        [dqpc_pkg::ANGLE_OUT_W-1:0] angle_out;

  modport source (output valid, vd, vq, id_out, iq_out, p_active, q_reactive, angle_out,
                  input ready);
  modport sink   (input valid, vd, vq, id_out, iq_out, p_active, q_reactive, angle_out,
                  output ready);
endinterface

>>> design/dq_frame_power_calculator_top.sv
// Top level of the three-phase to dq frame power calculator.
//
// Requests arrive on in_i, one set of phase voltage and current samples each.
// For every request the phase accumulator advances by angle_step, and both
// triples are mapped to the d/q frame at the new angle by the power-invariant
// Park transform. The result on out_o holds vd, vq, id, iq (saturated to 18
// bits), active and reactive power, and the angle used.
// angle_step is written through angle_step_we_i / angle_step_i; the user must
// do so only while idle, as the block itself does not enforce it.
// The sequencer walks the three phase angles through one table lookup and one
// multiply-accumulate step each, then scales, rounds and forms the power products.
// A new request is taken only once the sequencer has returned to idle.
// The result sits in an output register, so a new request is taken while it
// waits; if the receiver still stalls when the next result is done, the
// block holds that result internally and accepts nothing until it moves.
// Reset clears the phase accumulator, angle_step and all valid state.
module dq_frame_power_calculator_top #(
  parameter int ANGLE_BITS      = dqpc_pkg::ANGLE_BITS_DEF,
  parameter int SAMPLE_BITS     = dqpc_pkg::SAMPLE_BITS_DEF,
  parameter int SINE_TABLE_BITS = dqpc_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          angle_step_we_i,
  input  logic [dqpc_pkg::STEP_W-1:0]   angle_step_i,
  dqpc_in_if.sink                       in_i,
  dqpc_out_if.source                    out_o
);
  import dqpc_pkg::*;

  cmd_t cmd;

  dqpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  dqpc_datapath #(
    .ANGLE_BITS      (ANGLE_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .angle_step_we_i (angle_step_we_i),
    .angle_step_i    (angle_step_i),
    .va_i            (in_i.va),
    .vb_i            (in_i.vb),
    .vc_i            (in_i.vc),
    .ia_i            (in_i.ia),
    .ib_i            (in_i.ib),
    .ic_i            (in_i.ic),
    .vd_o            (out_o.vd),
    .vq_o            (out_o.vq),
    .id_out_o        (out_o.id_out),
    .iq_out_o        (out_o.iq_out),
    .p_active_o      (out_o.p_active),
    .q_reactive_o    (out_o.q_reactive),
    .angle_out_o     (out_o.angle_out)
  );

  // An accepted request starts the first table lookup and blocks new requests.
  a_accept_starts_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (cmd.lookup && !in_i.ready))
    else $error("accepted request did not start the lookup sequence");

  // At most one datapath command is active in any cycle.
  a_cmd_onehot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load_in, cmd.lookup, cmd.mac, cmd.scale, cmd.rnd, cmd.load_out}))
    else $error("more than one datapath command active");

  // A result only becomes valid right after the output register was loaded.
  a_valid_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd.load_out))
    else $error("result valid without an output load");

  // The output register is never overwritten while its result is stalled.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !cmd.load_out)
    else $error("stalled result overwritten");

endmodule

>>> design/dqpc_ctrl.sv
// Controller state machine sequencing lookups, accumulation, scaling and output.
module dqpc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dqpc_pkg::cmd_t cmd_o
);
  import dqpc_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_LOOKUP = 6'b000010,
    ST_MAC    = 6'b000100,
    ST_SCALE  = 6'b001000,
    ST_RND    = 6'b010000,
    ST_POWER  = 6'b100000
  } state_e;

  state_e     state_q, state_d;
  phase_sel_e phase_q, phase_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    cmd_o      = '0;
    cmd_o.phase = phase_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          phase_d       = PH_A;
          state_d       = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = ST_MAC;
      end
      ST_MAC: begin
        cmd_o.mac = 1'b1;
        unique case (phase_q)
          PH_A: begin
            phase_d = PH_B;
            state_d = ST_LOOKUP;
          end
          PH_B: begin
            phase_d = PH_C;
            state_d = ST_LOOKUP;
          end
          default: begin
            phase_d = PH_A;
            state_d = ST_SCALE;
          end
        endcase
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_RND;
      end
      ST_RND: begin
        cmd_o.rnd = 1'b1;
        state_d   = ST_POWER;
      end
      ST_POWER: begin
        // Results move to the output register only once it is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_A;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> design/dqpc_datapath.sv
// Datapath: phase accumulator, sine table, Park transform lanes and power products.
module dqpc_datapath #(
  parameter int ANGLE_BITS      = dqpc_pkg::ANGLE_BITS_DEF,
  parameter int SAMPLE_BITS     = dqpc_pkg::SAMPLE_BITS_DEF,
  parameter int SINE_TABLE_BITS = dqpc_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  dqpc_pkg::cmd_t                          cmd_i,
  input  logic                                    angle_step_we_i,
  input  logic        [dqpc_pkg::STEP_W-1:0]      angle_step_i,
  input  logic signed [dqpc_pkg::SAMPLE_W-1:0]    va_i,
  input  logic signed [dqpc_pkg::SAMPLE_W-1:0]    vb_i,
  input  logic signed [dqpc_pkg::SAMPLE_W-1:0]    vc_i,
  input  logic signed [dqpc_pkg::SAMPLE_W-1:0]    ia_i,
  input  logic signed [dqpc_pkg::SAMPLE_W-1:0]    ib_i,
  input  logic signed [dqpc_pkg::SAMPLE_W-1:0]    ic_i,
  output logic signed [dqpc_pkg::DQ_W-1:0]        vd_o,
  output logic signed [dqpc_pkg::DQ_W-1:0]        vq_o,
  output logic signed [dqpc_pkg::DQ_W-1:0]        id_out_o,
  output logic signed [dqpc_pkg::DQ_W-1:0]        iq_out_o,
  output logic signed [dqpc_pkg::PWR_W-1:0]       p_active_o,
  output logic signed [dqpc_pkg::PWR_W-1:0]       q_reactive_o,
  output logic        [dqpc_pkg::ANGLE_OUT_W-1:0] angle_out_o
);
  import dqpc_pkg::*;

  localparam int AB         = ANGLE_BITS;
  localparam int SB         = SAMPLE_BITS;
  localparam int TB         = SINE_TABLE_BITS;
  localparam int QuarterLen = 1 << TB;
  localparam int TabEntries = QuarterLen + 1;
  localparam int PhW        = TB + 2;
  localparam int ExtW       = (SB > SAMPLE_W) ? SB : SAMPLE_W;
  localparam int ProdW      = SB + 16;
  localparam int AccW       = SB + 17;
  localparam int ScW        = AccW + 16;

  localparam logic [63:0] ThirdFull = ((64'd2 << AB) + 64'd3) / 64'd6;
  localparam logic [AB-1:0] AngleThird   = ThirdFull[AB-1:0];
  localparam logic [AB-1:0] AngleQuarter = AB'(64'd1 << (AB - 2));

  localparam logic signed [ScW-1:0] KScaled = ScW'(K_Q15);
  localparam logic signed [ScW-1:0] HalfLsb = ScW'(64'd1 << 29);
  localparam logic signed [ScW-1:0] DqMax   = ScW'(DQ_MAX);
  localparam logic signed [ScW-1:0] DqMin   = ScW'(DQ_MIN);
  localparam logic [TB:0]           QuarterAddr = (TB + 1)'(QuarterLen);

  typedef logic [14:0] tab_t [TabEntries];

  // Quarter-wave sine in Q0.15 from a truncating Q30 Horner series, built at elaboration.
  function automatic tab_t build_tab();
    tab_t        tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] e;
    for (int n = 0; n < TabEntries; n++) begin
      x  = (HALF_PI_Q30 * 64'(n)) >> TB;
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      e  = (s * 64'd32768 + (ONE_Q30 >> 1)) >> 30;
      if (e > 64'd32767) begin
        e = 64'd32767;
      end
      tab[n] = e[14:0];
    end
    return tab;
  endfunction

  localparam tab_t SineTab = build_tab();

  // Round half up at 2^-30, then clamp to the 18-bit d/q range.
  function automatic logic signed [DQ_W-1:0] round_sat(input logic signed [ScW-1:0] x);
    logic signed [ScW-1:0] r;
    r = (x + HalfLsb) >>> 30;
    if (r > DqMax) begin
      r = DqMax;
    end else if (r < DqMin) begin
      r = DqMin;
    end
    return r[DQ_W-1:0];
  endfunction

  function automatic logic signed [SB-1:0] take_sample(input logic signed [SAMPLE_W-1:0] x);
    logic [ExtW-1:0] ext;
    ext = ExtW'($unsigned(x));
    return $signed(ext[SB-1:0]);
  endfunction

  function automatic logic signed [15:0] signed_trig(input logic [14:0] mag, input logic neg);
    logic signed [15:0] v;
    v = $signed({1'b0, mag});
    return neg ? -v : v;
  endfunction

  logic [STEP_W-1:0]     angle_step_q;
  logic [AB-1:0]         phase_q;
  logic signed [SB-1:0]  va_q, vb_q, vc_q, ia_q, ib_q, ic_q;

  logic [AB-1:0]         angle_k;
  logic [AB-1:0]         cos_angle;
  logic [PhW-1:0]        sin_p, cos_p;
  logic [TB:0]           sin_addr, cos_addr;

  logic [14:0]           sin_mag_q, cos_mag_q;
  logic                  sin_neg_q, cos_neg_q;
  logic signed [15:0]    sin_t, cos_t;
  logic signed [SB-1:0]  v_sel, i_sel;
  logic signed [ProdW-1:0] prod_vc, prod_vs, prod_ic, prod_is;

  logic signed [AccW-1:0] acc_vc_q, acc_vs_q, acc_ic_q, acc_is_q;
  logic signed [ScW-1:0]  sc_vd_q, sc_vq_q, sc_id_q, sc_iq_q;
  logic signed [DQ_W-1:0] dq_vd_q, dq_vq_q, dq_id_q, dq_iq_q;
  logic signed [2*DQ_W-1:0] pr_dd, pr_qq, pr_qd, pr_dq;

  // Configuration and phase accumulator.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_step_q <= '0;
      phase_q      <= '0;
    end else begin
      if (angle_step_we_i) begin
        angle_step_q <= angle_step_i;
      end
      if (cmd_i.load_in) begin
        phase_q <= phase_q + AB'(angle_step_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      va_q <= take_sample(va_i);
      vb_q <= take_sample(vb_i);
      vc_q <= take_sample(vc_i);
      ia_q <= take_sample(ia_i);
      ib_q <= take_sample(ib_i);
      ic_q <= take_sample(ic_i);
    end
  end

  always_comb begin
    unique case (cmd_i.phase)
      PH_A: begin
        angle_k = phase_q;
        v_sel   = va_q;
        i_sel   = ia_q;
      end
      PH_B: begin
        angle_k = phase_q - AngleThird;
        v_sel   = vb_q;
        i_sel   = ib_q;
      end
      PH_C: begin
        angle_k = phase_q + AngleThird;
        v_sel   = vc_q;
        i_sel   = ic_q;
      end
      default: begin
        angle_k = phase_q;
        v_sel   = va_q;
        i_sel   = ia_q;
      end
    endcase
  end

  assign cos_angle = angle_k + AngleQuarter;

  // Table position is the top TB+2 bits of the angle, zero-padded when the angle is narrower.
  if (AB >= PhW) begin : g_phase_cut
    assign sin_p = angle_k[AB-1 -: PhW];
    assign cos_p = cos_angle[AB-1 -: PhW];
  end else begin : g_phase_pad
    assign sin_p = {angle_k, {(PhW - AB){1'b0}}};
    assign cos_p = {cos_angle, {(PhW - AB){1'b0}}};
  end

  // Odd quadrants read the table backwards.
  assign sin_addr = sin_p[TB] ? QuarterAddr - {1'b0, sin_p[TB-1:0]} : {1'b0, sin_p[TB-1:0]};
  assign cos_addr = cos_p[TB] ? QuarterAddr - {1'b0, cos_p[TB-1:0]} : {1'b0, cos_p[TB-1:0]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      sin_mag_q <= SineTab[sin_addr];
      cos_mag_q <= SineTab[cos_addr];
      sin_neg_q <= sin_p[TB+1];
      cos_neg_q <= cos_p[TB+1];
    end
  end

  assign sin_t   = signed_trig(sin_mag_q, sin_neg_q);
  assign cos_t   = signed_trig(cos_mag_q, cos_neg_q);
  assign prod_vc = v_sel * cos_t;
  assign prod_vs = v_sel * sin_t;
  assign prod_ic = i_sel * cos_t;
  assign prod_is = i_sel * sin_t;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      acc_vc_q <= '0;
      acc_vs_q <= '0;
      acc_ic_q <= '0;
      acc_is_q <= '0;
    end else if (cmd_i.mac) begin
      acc_vc_q <= acc_vc_q + AccW'(prod_vc);
      acc_vs_q <= acc_vs_q + AccW'(prod_vs);
      acc_ic_q <= acc_ic_q + AccW'(prod_ic);
      acc_is_q <= acc_is_q + AccW'(prod_is);
    end
  end

  // The q axis carries the negated sine sum.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      sc_vd_q <= ScW'(acc_vc_q) * KScaled;
      sc_vq_q <= -(ScW'(acc_vs_q) * KScaled);
      sc_id_q <= ScW'(acc_ic_q) * KScaled;
      sc_iq_q <= -(ScW'(acc_is_q) * KScaled);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rnd) begin
      dq_vd_q <= round_sat(sc_vd_q);
      dq_vq_q <= round_sat(sc_vq_q);
      dq_id_q <= round_sat(sc_id_q);
      dq_iq_q <= round_sat(sc_iq_q);
    end
  end

  assign pr_dd = dq_vd_q * dq_id_q;
  assign pr_qq = dq_vq_q * dq_iq_q;
  assign pr_qd = dq_vq_q * dq_id_q;
  assign pr_dq = dq_vd_q * dq_iq_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      vd_o         <= dq_vd_q;
      vq_o         <= dq_vq_q;
      id_out_o     <= dq_id_q;
      iq_out_o     <= dq_iq_q;
      p_active_o   <= PWR_W'(pr_dd) + PWR_W'(pr_qq);
      q_reactive_o <= PWR_W'(pr_qd) - PWR_W'(pr_dq);
      angle_out_o  <= ANGLE_OUT_W'(phase_q);
    end
  end

endmodule

>>> bench/tb_dq_frame_power_calculator_top.sv
// Self-checking testbench for the three-phase to dq frame power calculator.
`timescale 1ns / 1ps

module tb_dq_frame_power_calculator_top;
  import dqpc_pkg::*;

  localparam int ANGLE_W       = ANGLE_BITS_DEF;
  localparam int TABLE_BITS    = SINE_TABLE_BITS_DEF;
  localparam int QUARTER_LEN   = 1 << TABLE_BITS;
  localparam int ANGLE_THIRD   = ((2 << ANGLE_W) + 3) / 6;
  localparam int ANGLE_QUARTER = 1 << (ANGLE_W - 2);
  localparam int IDLE_PCT      = 37;
  localparam int DRAIN_CYCLES  = 12;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] va;
    logic signed [SAMPLE_W-1:0] vb;
    logic signed [SAMPLE_W-1:0] vc;
    logic signed [SAMPLE_W-1:0] ia;
    logic signed [SAMPLE_W-1:0] ib;
    logic signed [SAMPLE_W-1:0] ic;
  } phase_samples_t;

  typedef struct packed {
    logic signed [DQ_W-1:0]     vd;
    logic signed [DQ_W-1:0]     vq;
    logic signed [DQ_W-1:0]     id_val;
    logic signed [DQ_W-1:0]     iq_val;
    logic signed [PWR_W-1:0]    p_act;
    logic signed [PWR_W-1:0]    q_react;
    logic [ANGLE_OUT_W-1:0]     angle;
  } dq_power_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              angle_step_we_i;
  logic [STEP_W-1:0] angle_step_i;

  dqpc_in_if  in_if ();
  dqpc_out_if out_if ();

  dq_frame_power_calculator_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .angle_step_we_i (angle_step_we_i),
    .angle_step_i    (angle_step_i),
    .in_i            (in_if),
    .out_o           (out_if)
  );

  always #10 clk_i = ~clk_i;

  int                   sine_q15 [0:QUARTER_LEN];
  phase_samples_t       pending_samples [$];
  dq_power_t            expected_dq [$];
  logic [ANGLE_W-1:0]   model_angle;
  logic [STEP_W-1:0]    model_step;
  logic                 request_taken;
  logic                 calm;
  int                   mismatches;
  dq_power_t            got_dq;
  dq_power_t            want_dq;

  // Quarter-wave table: unsigned Q30 Horner series, then rounded half up to Q15.
  function automatic void build_sine_table();
    longint unsigned divs [5];
    longint unsigned x, x2, t, s, e;
    divs = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
    for (int n = 0; n <= QUARTER_LEN; n++) begin
      x  = (HALF_PI_Q30 * longint'(n)) >> TABLE_BITS;
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      for (int j = 0; j < 5; j++) begin
        t = ONE_Q30 - ((x2 * t) >> 30) / divs[j];
      end
      s = (x * t) >> 30;
      e = (s * 64'd32768 + (ONE_Q30 >> 1)) >> 30;
      if (e > 64'd32767) begin
        e = 64'd32767;
      end
      sine_q15[n] = int'(e);
    end
  endfunction

  function automatic longint sin_q15(input logic [ANGLE_W-1:0] a);
    logic [TABLE_BITS+1:0] p;
    logic [1:0]            quad;
    logic [TABLE_BITS-1:0] r;
    longint                mag;
    p    = a[ANGLE_W-1 -: TABLE_BITS+2];
    quad = p[TABLE_BITS+1:TABLE_BITS];
    r    = p[TABLE_BITS-1:0];
    mag  = quad[0] ? sine_q15[QUARTER_LEN - int'(r)] : sine_q15[r];
    return quad[1] ? -mag : mag;
  endfunction

  function automatic logic signed [DQ_W-1:0] scale_round_sat(input longint acc);
    longint v;
    // Adding half an LSB and flooring gives round half towards +infinity.
    v = (acc * K_Q15 + (longint'(1) << 29)) >>> 30;
    if (v > DQ_MAX) begin
      v = DQ_MAX;
    end else if (v < DQ_MIN) begin
      v = DQ_MIN;
    end
    return v[DQ_W-1:0];
  endfunction

  function automatic void park_dq(input logic [ANGLE_W-1:0] a,
                                  input logic signed [SAMPLE_W-1:0] xa, xb, xc,
                                  output logic signed [DQ_W-1:0] d, q);
    logic [ANGLE_W-1:0] am;
    logic [ANGLE_W-1:0] ap;
    longint             sc;
    longint             ss;
    am = a - ANGLE_W'(ANGLE_THIRD);
    ap = a + ANGLE_W'(ANGLE_THIRD);
    sc = longint'(xa) * sin_q15(a + ANGLE_W'(ANGLE_QUARTER))
       + longint'(xb) * sin_q15(am + ANGLE_W'(ANGLE_QUARTER))
       + longint'(xc) * sin_q15(ap + ANGLE_W'(ANGLE_QUARTER));
    ss = longint'(xa) * sin_q15(a) + longint'(xb) * sin_q15(am)
       + longint'(xc) * sin_q15(ap);
    d = scale_round_sat(sc);
    q = scale_round_sat(-ss);
  endfunction

  function automatic dq_power_t predict_power(input logic [ANGLE_W-1:0] a,
                                              input phase_samples_t s);
    dq_power_t              r;
    logic signed [DQ_W-1:0] vd, vq, idv, iqv;
    longint                 p, q;
    park_dq(a, s.va, s.vb, s.vc, vd, vq);
    park_dq(a, s.ia, s.ib, s.ic, idv, iqv);
    p = longint'(vd) * longint'(idv) + longint'(vq) * longint'(iqv);
    q = longint'(vq) * longint'(idv) - longint'(vd) * longint'(iqv);
    r.vd      = vd;
    r.vq      = vq;
    r.id_val  = idv;
    r.iq_val  = iqv;
    r.p_act   = p[PWR_W-1:0];
    r.q_react = q[PWR_W-1:0];
    r.angle   = a;
    return r;
  endfunction

  // Driver: presents queued requests at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_if.valid || request_taken)) begin
      request_taken = 1'b0;
      if (pending_samples.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        {in_if.va, in_if.vb, in_if.vc, in_if.ia, in_if.ib, in_if.ic} <=
          pending_samples.pop_front();
        in_if.valid <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Each accepted request advances the angle model and queues its result.
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      request_taken = 1'b1;
      model_angle = model_angle + model_step[ANGLE_W-1:0];
      expected_dq.insert(expected_dq.size(), predict_power(model_angle,
        {in_if.va, in_if.vb, in_if.vc, in_if.ia, in_if.ib, in_if.ic}));
    end
  end

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      got_dq = {out_if.vd, out_if.vq, out_if.id_out, out_if.iq_out,
                out_if.p_active, out_if.q_reactive, out_if.angle_out};
      if (expected_dq.size() == 0) begin
        $error("result with no request outstanding, angle_out %0d", got_dq.angle);
        mismatches++;
      end else begin
        want_dq = expected_dq.pop_front();
        compare_field("vd", want_dq.vd, got_dq.vd);
        compare_field("vq", want_dq.vq, got_dq.vq);
        compare_field("id_out", want_dq.id_val, got_dq.id_val);
        compare_field("iq_out", want_dq.iq_val, got_dq.iq_val);
        compare_field("p_active", want_dq.p_act, got_dq.p_act);
        compare_field("q_reactive", want_dq.q_react, got_dq.q_react);
        compare_field("angle_out", want_dq.angle, got_dq.angle);
      end
    end
  end

  task automatic push_samples(input int va, vb, vc, ia, ib, ic);
    phase_samples_t s;
    s.va = va[SAMPLE_W-1:0];
    s.vb = vb[SAMPLE_W-1:0];
    s.vc = vc[SAMPLE_W-1:0];
    s.ia = ia[SAMPLE_W-1:0];
    s.ib = ib[SAMPLE_W-1:0];
    s.ic = ic[SAMPLE_W-1:0];
    pending_samples.insert(pending_samples.size(), s);
  endtask

  function automatic int pick_sample(input bit corner);
    int corners [4];
    corners = '{-32768, 32767, 0, -1};
    if (corner) begin
      return corners[$urandom_range(3)];
    end
    return int'($urandom_range(65535)) - 32768;
  endfunction

  task automatic push_random_burst(input int count);
    bit corner;
    for (int k = 0; k < count; k++) begin
      // One request in ten uses corner values on every phase.
      corner = ($urandom_range(9) == 0);
      push_samples(pick_sample(corner), pick_sample(corner), pick_sample(corner),
                   pick_sample(corner), pick_sample(corner), pick_sample(corner));
    end
  endtask

  // Waits until every request is accepted and answered, then lets the pipe settle.
  task automatic drain();
    while (pending_samples.size() > 0 || in_if.valid || expected_dq.size() > 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_step(input logic [STEP_W-1:0] value);
    @(negedge clk_i);
    angle_step_we_i <= 1'b1;
    angle_step_i    <= value;
    @(negedge clk_i);
    angle_step_we_i <= 1'b0;
    model_step = value;
  endtask

  initial begin
    #(64'd5_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    build_sine_table();
    rst_ni          = 1'b0;
    angle_step_we_i = 1'b0;
    angle_step_i    = '0;
    in_if.valid     = 1'b0;
    in_if.va        = '0;
    in_if.vb        = '0;
    in_if.vc        = '0;
    in_if.ia        = '0;
    in_if.ib        = '0;
    in_if.ic        = '0;
    out_if.ready    = 1'b0;
    model_angle     = '0;
    model_step      = '0;
    request_taken   = 1'b0;
    calm            = 1'b0;
    mismatches      = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Step left at its reset value: the angle stays at zero.
    push_samples(32767, 32767, 32767, 32767, 32767, 32767);
    push_samples(-32768, -32768, -32768, -32768, -32768, -32768);
    push_samples(0, 0, 0, 0, 0, 0);
    push_samples(32767, -32768, -32768, -32768, 32767, 32767);
    push_samples(-32768, 32767, 32767, 32767, -32768, -32768);
    push_samples(-1, 1, -1, 1, -1, 1);
    push_samples(20000, -10000, -10000, 15000, -7500, -7500);
    drain();

    // Quarter turns land on both ends of the table and on every quadrant.
    write_step(16'h4000);
    push_samples(32767, -16384, -16384, 32767, -16384, -16384);
    push_samples(-32768, 32767, 0, 0, 32767, -32768);
    push_samples(32767, 32767, 32767, -32768, -32768, -32768);
    push_samples(12345, -23456, 11111, -30000, 30000, 1);
    push_samples(32767, -32768, 32767, -32768, 32767, -32768);
    drain();

    // The largest step walks the accumulator backwards.
    write_step(16'hFFFF);
    push_samples(32767, 0, -32768, 0, 32767, -32768);
    push_samples(-32768, 32767, -32768, 32767, -32768, 32767);
    push_samples(1000, 2000, -3000, -1000, -2000, 3000);
    drain();

    write_step(16'(ANGLE_THIRD));
    push_samples(32767, -32768, 0, 0, 32767, -32768);
    push_samples(-20000, 10000, 10000, 25000, -12500, -12500);
    push_samples(-32768, -32768, 32767, 32767, 32767, -32768);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      unique case (ph)
        0: begin
          write_step(16'h0001);
        end
        2: begin
          write_step(16'h8000);
        end
        4: begin
          write_step(16'h0000);
        end
        default: begin
          write_step(16'($urandom_range(65535)));
        end
      endcase
      // One phase runs with both sides always ready.
      calm = (ph == 2);
      push_random_burst(80);
      drain();
    end
    calm = 1'b0;

    if (mismatches == 0 && expected_dq.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> dq_frame_power_calculator_top.f
design/dqpc_pkg.sv
design/dqpc_in_if.sv
design/dqpc_out_if.sv
design/dqpc_ctrl.sv
design/dqpc_datapath.sv
design/dq_frame_power_calculator_top.sv
bench/tb_dq_frame_power_calculator_top.sv
